>>> design/cae_pkg.sv
// Shared types, codes and the LPS range table of the CABAC arithmetic encoder.
package cae_pkg;

    typedef enum logic [1:0] {
        OP_REGULAR = 2'd0,
        OP_BYPASS  = 2'd1,
        OP_TERM    = 2'd2,
        OP_FLUSH   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_HELD,
        ST_FILL,
        ST_FIN,
        ST_PAD,
        ST_TAIL
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [7:0] value;
        logic [3:0] count;
        logic [5:0] ctx_state;
        logic       ctx_mps;
        logic       bin;
    } t_item;

    localparam logic [8:0] C_RANGE_INIT = 9'd510;
    localparam logic [4:0] C_BITS_INIT  = 5'd23;
    localparam logic [7:0] C_HELD_INIT  = 8'hff;
    localparam logic [4:0] C_BITS_MIN   = 5'd12;

    localparam logic [0:3][7:0] C_LPS [64] = '{
        '{128,176,208,240}, '{128,167,197,227}, '{128,158,187,216}, '{123,150,178,205},
        '{116,142,169,195}, '{111,135,160,185}, '{105,128,152,175}, '{100,122,144,166},
        '{95,116,137,158},  '{90,110,130,150},  '{85,104,123,142},  '{81,99,117,135},
        '{77,94,111,128},   '{73,89,105,122},   '{69,85,100,116},   '{66,80,95,110},
        '{62,76,90,104},    '{59,72,86,99},     '{56,69,81,94},     '{53,65,77,89},
        '{51,62,73,85},     '{48,59,69,80},     '{46,56,66,76},     '{43,53,63,72},
        '{41,50,59,69},     '{39,48,56,65},     '{37,45,54,62},     '{35,43,51,59},
        '{33,41,48,56},     '{32,39,46,53},     '{30,37,43,50},     '{29,35,41,48},
        '{27,33,39,45},     '{26,31,37,43},     '{24,30,35,41},     '{23,28,33,39},
        '{22,27,32,37},     '{21,26,30,35},     '{20,24,29,33},     '{19,23,27,31},
        '{18,22,26,30},     '{17,21,25,28},     '{16,20,23,27},     '{15,19,22,25},
        '{14,18,21,24},     '{14,17,20,23},     '{13,16,19,22},     '{12,15,18,21},
        '{12,14,17,20},     '{11,14,16,19},     '{11,13,15,18},     '{10,12,15,17},
        '{10,12,14,16},     '{9,11,13,15},      '{9,11,12,14},      '{8,10,12,14},
        '{8,9,11,13},       '{7,9,11,12},       '{7,9,10,12},       '{7,8,10,11},
        '{6,8,9,11},        '{6,7,9,10},        '{6,7,8,9},         '{2,2,2,2}
    };

endpackage

>>> design/cae_front.sv
// Input side: accepts operations, normalizes bypass fields and queues them for the engine.
module cae_front import cae_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_bin_value,
    input  logic [3:0] i_bin_count,
    input  logic [5:0] i_ctx_state,
    input  logic       i_ctx_mps,
    output logic       o_item_valid,
    output t_item      o_item,
    input  logic       i_item_pop
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    t_item          item_in;
    logic [3:0]     cnt_sat;
    logic [7:0]     mask;
    logic           push;
    logic           pop;

    always_comb begin
        cnt_sat = (i_bin_count > 4'd8) ? 4'd8 : i_bin_count;
        for (int k = 0; k < 8; k++) begin
            mask[k] = (4'(k) < cnt_sat);
        end
        item_in.op        = t_op'(i_opcode);
        item_in.value     = i_bin_value & mask;
        item_in.count     = cnt_sat;
        item_in.ctx_state = i_ctx_state;
        item_in.ctx_mps   = i_ctx_mps;
        item_in.bin       = i_bin_value[0];
    end

    assign o_ready      = (r_cnt < CW'(DEPTH));
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_cnt != '0);
    assign pop          = i_item_pop && o_item_valid;
    assign o_item       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= item_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

>>> design/cae_back.sv
// Engine: interval arithmetic, byte output with carry resolution, flush sequencing.
module cae_back import cae_pkg::*; #(
    parameter int PENDING_MAX = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_item_valid,
    input  t_item      i_item,
    output logic       o_item_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    output logic       o_overflow
);
    t_state      r_state, n_state;
    logic [31:0] r_low, n_low;
    logic [8:0]  r_range, n_range;
    logic [4:0]  r_bits, n_bits;
    logic [7:0]  r_held, n_held;
    logic [4:0]  r_pend, n_pend;
    logic        r_ovf, n_ovf;
    logic        r_flush, n_flush;
    logic        r_fin, n_fin;
    logic [7:0]  r_hbyte, n_hbyte;
    logic [7:0]  r_fill, n_fill;
    logic [15:0] r_acc, n_acc;
    logic [1:0]  r_nbytes, n_nbytes;
    logic        r_ovalid, n_ovalid;
    logic [7:0]  r_obyte, n_obyte;
    logic        r_olast, n_olast;
    logic        r_oovf, n_oovf;

    logic        emit_ok;
    logic        emit;
    logic [7:0]  emit_byte;
    logic        emit_last;
    logic        take;

    logic [0:3][7:0] lps_row;
    logic [7:0]  lps;
    logic [8:0]  rmps;
    logic [8:0]  rterm;
    logic [2:0]  shf;
    logic [31:0] lead;
    logic [4:0]  bits_up;
    logic        carry;
    logic        wr_needed;
    logic        wr_emit;
    logic [4:0]  fin_sh;
    logic        fin_carry;
    logic [3:0]  nb;
    logic [11:0] pad_bits;
    logic [3:0]  nb1;
    logic [2:0]  pad;
    logic [15:0] acc1;
    logic [4:0]  nb_tot;
    logic [31:0] tlow;

    assign emit_ok    = !r_ovalid || i_ready;
    assign take       = (r_state == ST_IDLE) && i_item_valid;
    assign o_item_pop = take;

    always_comb begin
        lps_row = C_LPS[i_item.ctx_state];
        lps     = lps_row[r_range[7:6]];
        rmps    = r_range - {1'b0, lps};
        rterm   = r_range - 9'd2;
        priority if (lps[7]) shf = 3'd1;
        else if (lps[6])     shf = 3'd2;
        else if (lps[5])     shf = 3'd3;
        else if (lps[4])     shf = 3'd4;
        else if (lps[3])     shf = 3'd5;
        else if (lps[2])     shf = 3'd6;
        else                 shf = 3'd7;
        lead      = r_low >> (5'd24 - r_bits);
        bits_up   = r_bits + 5'd8;
        carry     = lead[8];
        wr_needed = (r_bits < C_BITS_MIN);
        wr_emit   = wr_needed && (lead != 32'hff) && (r_pend != '0);
        fin_sh    = 5'(6'd32 - {1'b0, r_bits});
        fin_carry = ((r_low >> fin_sh) != '0);
        nb        = 4'(5'd24 - r_bits);
        pad_bits  = 12'((r_low >> 8) & ((32'd1 << nb) - 32'd1));
        nb1       = nb + 4'd1;
        pad       = 3'(4'd0 - nb1);
        acc1      = {3'b0, pad_bits, 1'b1} << pad;
        nb_tot    = {1'b0, nb1} + {2'b0, pad};
        tlow      = r_low + 32'(rterm);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_item_valid) n_state = ST_WRITE;
            ST_WRITE: begin
                if (wr_emit)      n_state = ST_HELD;
                else if (r_flush) n_state = ST_FIN;
                else              n_state = ST_IDLE;
            end
            ST_HELD:  if (emit_ok) n_state = ST_FILL;
            ST_FILL: begin
                if (r_pend <= 5'd1) begin
                    if (!r_flush)   n_state = ST_IDLE;
                    else if (!r_fin) n_state = ST_FIN;
                    else            n_state = ST_PAD;
                end
            end
            ST_FIN: begin
                if (fin_carry || r_pend != '0) n_state = ST_HELD;
                else                           n_state = ST_FILL;
            end
            ST_PAD:   n_state = ST_TAIL;
            ST_TAIL:  if (emit_ok && r_nbytes == 2'd1) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // datapath and output
    always_comb begin
        n_low     = r_low;
        n_range   = r_range;
        n_bits    = r_bits;
        n_held    = r_held;
        n_pend    = r_pend;
        n_ovf     = r_ovf;
        n_flush   = r_flush;
        n_fin     = r_fin;
        n_hbyte   = r_hbyte;
        n_fill    = r_fill;
        n_acc     = r_acc;
        n_nbytes  = r_nbytes;
        emit      = 1'b0;
        emit_byte = r_hbyte;
        emit_last = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    n_flush = (i_item.op == OP_FLUSH);
                    n_fin   = 1'b0;
                    unique case (i_item.op)
                        OP_REGULAR: begin
                            if (i_item.bin != i_item.ctx_mps) begin
                                n_low   = (r_low + 32'(rmps)) << shf;
                                n_range = {1'b0, lps} << shf;
                                n_bits  = r_bits - 5'(shf);
                            end else if (!rmps[8]) begin
                                n_low   = r_low << 1;
                                n_range = rmps << 1;
                                n_bits  = r_bits - 5'd1;
                            end else begin
                                n_range = rmps;
                            end
                        end
                        OP_BYPASS: begin
                            n_low  = (r_low << i_item.count)
                                   + (32'(r_range) * 32'(i_item.value));
                            n_bits = r_bits - 5'(i_item.count);
                        end
                        OP_TERM, OP_FLUSH: begin
                            if (i_item.bin || i_item.op == OP_FLUSH) begin
                                n_low   = tlow << 7;
                                n_range = 9'd256;
                                n_bits  = r_bits - 5'd7;
                            end else if (!rterm[8]) begin
                                n_low   = r_low << 1;
                                n_range = rterm << 1;
                                n_bits  = r_bits - 5'd1;
                            end else begin
                                n_range = rterm;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WRITE: begin
                if (wr_needed) begin
                    n_bits = bits_up;
                    n_low  = r_low & (32'hffffffff >> bits_up);
                    if (lead == 32'hff) begin
                        if (r_pend >= 5'(PENDING_MAX)) n_ovf = 1'b1;
                        else                           n_pend = r_pend + 5'd1;
                    end else if (r_pend != '0) begin
                        n_hbyte = r_held + {7'd0, carry};
                        n_held  = lead[7:0];
                        n_fill  = carry ? 8'h00 : 8'hff;
                    end else begin
                        n_pend = 5'd1;
                        n_held = lead[7:0];
                    end
                end
            end
            ST_HELD: begin
                emit      = emit_ok;
                emit_byte = r_hbyte;
            end
            ST_FILL: begin
                if (r_pend > 5'd1) begin
                    emit      = emit_ok;
                    emit_byte = r_fill;
                    if (emit_ok) n_pend = r_pend - 5'd1;
                end
            end
            ST_FIN: begin
                n_fin = 1'b1;
                if (fin_carry) begin
                    n_hbyte = r_held + 8'd1;
                    n_fill  = 8'h00;
                    n_low   = r_low - (32'd1 << fin_sh);
                end else begin
                    n_hbyte = r_held;
                    n_fill  = 8'hff;
                end
            end
            ST_PAD: begin
                n_acc    = acc1;
                n_nbytes = nb_tot[4:3];
            end
            ST_TAIL: begin
                emit      = emit_ok;
                emit_byte = (r_nbytes == 2'd2) ? r_acc[15:8] : r_acc[7:0];
                emit_last = (r_nbytes == 2'd1);
                if (emit_ok) begin
                    n_nbytes = r_nbytes - 2'd1;
                    if (r_nbytes == 2'd1) begin
                        n_low   = '0;
                        n_range = C_RANGE_INIT;
                        n_bits  = C_BITS_INIT;
                        n_held  = C_HELD_INIT;
                        n_pend  = '0;
                        n_flush = 1'b0;
                        n_fin   = 1'b0;
                    end
                end
            end
            default: ;
        endcase

        n_ovalid = r_ovalid && !i_ready;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        n_oovf   = r_oovf;
        if (emit) begin
            n_ovalid = 1'b1;
            n_obyte  = emit_byte;
            n_olast  = emit_last;
            n_oovf   = r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_low    <= '0;
            r_range  <= C_RANGE_INIT;
            r_bits   <= C_BITS_INIT;
            r_held   <= C_HELD_INIT;
            r_pend   <= '0;
            r_ovf    <= 1'b0;
            r_flush  <= 1'b0;
            r_fin    <= 1'b0;
            r_nbytes <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_low    <= n_low;
            r_range  <= n_range;
            r_bits   <= n_bits;
            r_held   <= n_held;
            r_pend   <= n_pend;
            r_ovf    <= n_ovf;
            r_flush  <= n_flush;
            r_fin    <= n_fin;
            r_nbytes <= n_nbytes;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hbyte <= n_hbyte;
        r_fill  <= n_fill;
        r_acc   <= n_acc;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
        r_oovf  <= n_oovf;
    end

    assign o_valid    = r_ovalid;
    assign o_out_byte = r_obyte;
    assign o_last     = r_olast;
    assign o_overflow = r_oovf;
endmodule

>>> design/cabac_arithmetic_encoder_unit.sv
// CABAC binary arithmetic encoder: top level joining the input queue and the engine.
// Operations (regular bin, 1..8 bypass bins, terminate bin, flush) enter a small queue and
// are taken by the engine one at a time. A regular, bypass or terminate operation occupies
// the engine for an interval update, then a byte check. When the byte check releases
// the held byte and its run of pending bytes (up to PENDING_MAX bytes), the engine
// emits them from its held and fill states before it takes the next operation.
// A flush adds a final carry step, padding and tail bytes; its final byte carries last.
// Output bytes leave through a single output register, one per cycle while taken;
// while the output register stays blocked, an engine state with a byte to emit waits.
// The overflow flag is sticky until reset.
module cabac_arithmetic_encoder_unit import cae_pkg::*; #(
    parameter int PENDING_MAX = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_bin_value,
    input  logic [3:0] i_bin_count,
    input  logic [5:0] i_ctx_state,
    input  logic       i_ctx_mps,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    output logic       o_overflow
);
    logic  item_valid;
    logic  item_pop;
    t_item item;

    cae_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_bin_value  (i_bin_value),
        .i_bin_count  (i_bin_count),
        .i_ctx_state  (i_ctx_state),
        .i_ctx_mps    (i_ctx_mps),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    cae_back #(.PENDING_MAX(PENDING_MAX)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last),
        .o_overflow   (o_overflow)
    );
endmodule

>>> design/cae_checker.sv
// Port-level assertions for the CABAC arithmetic encoder, bound to the top level.
module cae_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic       o_last,
    input logic       o_overflow
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_last))
        else $error("output transfer changed while stalled");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_overflow |=> !o_valid || o_overflow)
        else $error("overflow flag cleared without reset");

    a_reset_quiet: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");
endmodule

bind cabac_arithmetic_encoder_unit cae_checker u_cae_checker (.*);
